// ===== design/chord_template_matcher_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Chord template matcher assertion macros
// Shared concurrent checks used by the matcher unit's RTL.
// ----------------------------------------------------------------------------
`ifndef CHORD_TEMPLATE_MATCHER_UNIT_MACROS_SVH
`define CHORD_TEMPLATE_MATCHER_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define CTM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("chord matcher check failed");

// Check a consequence in the cycle after its antecedent.
`define CTM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("chord matcher check failed");

`endif

// ===== design/ctm_pkg.sv =====
// ----------------------------------------------------------------------------
// Chord template matcher package
// Widths, the chord template ROM and the candidate type shared by the modules.
// ----------------------------------------------------------------------------
package ctm_pkg;

    localparam int PC_W           = 12;
    localparam int PC_COUNT       = 12;
    localparam int ROOT_W         = 4;
    localparam int ROW_W          = 6;
    localparam int SCORE_W        = 2;
    localparam int CNT_W          = 4;
    localparam int TEMPLATE_COUNT = 34;
    localparam int S_DATA_W       = 16;
    localparam int M_DATA_W       = 16;

    typedef logic [PC_W-1:0]   pc_mask_t;
    typedef logic [ROOT_W-1:0] pc_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // Chord tones of each template, in priority order (row 0 = maj7(9)).
    localparam pc_mask_t TONES [TEMPLATE_COUNT] = '{
        12'h895, 12'h295, 12'h88D, 12'h48D, 12'h4A9, 12'h495, 12'h691, 12'h493,
        12'h499, 12'h591, 12'h4D5, 12'h8D5, 12'h451, 12'h911, 12'h511, 12'h891,
        12'h491, 12'h489, 12'h889, 12'h449, 12'h249, 12'h289, 12'h291, 12'h4A1,
        12'h095, 12'h08D, 12'h091, 12'h089, 12'h049, 12'h111, 12'h0A1, 12'h085,
        12'h081, 12'h001
    };

    // Tones that must be played for the template to apply.
    localparam pc_mask_t NEEDED [TEMPLATE_COUNT] = '{
        12'h815, 12'h215, 12'h80D, 12'h40D, 12'h429, 12'h415, 12'h611, 12'h413,
        12'h419, 12'h591, 12'h4D1, 12'h851, 12'h451, 12'h911, 12'h511, 12'h811,
        12'h411, 12'h409, 12'h809, 12'h449, 12'h249, 12'h209, 12'h211, 12'h421,
        12'h015, 12'h00D, 12'h091, 12'h089, 12'h049, 12'h111, 12'h021, 12'h005,
        12'h081, 12'h001
    };

    // Population count of each TONES entry.
    localparam cnt_t TONE_COUNT [TEMPLATE_COUNT] = '{
        4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
        4'd5, 4'd5, 4'd6, 4'd6, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
        4'd4, 4'd4, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
        4'd2, 4'd1
    };

    // Best reading for one root, or the overall winner.
    typedef struct packed {
        logic              found;
        logic [SCORE_W-1:0] score;
        row_t              row;
        pc_t               root;
    } ctm_cand_t;

endpackage

// ===== design/chord_template_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// Chord template matcher unit
// Recognises a chord from a pitch-class set and a bass pitch class.
// ----------------------------------------------------------------------------
// One result item leaves for every input item, in order. A new item is taken
// every cycle unless a stalled output has backed up all three register stages
// (input, per-root best reading, result); each stage drains into the next as
// soon as that one is free, so throughput is one item per cycle while the
// output is ready and a waiting result does not stop the earlier stages from
// filling. For each of the twelve roots the set is rotated onto the root and
// checked against the 34-row chord ROM; the winning reading is a found one with
// the highest score (2 for an exact cover, plus 1 when the root is the bass),
// then the lowest ROM row, then the lowest root. min_chord_tones may be
// written only while the unit is idle; it resets to 1.
// ----------------------------------------------------------------------------
`include "chord_template_matcher_unit_macros.svh"

module chord_template_matcher_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: min_chord_tones
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ctm_pkg::CNT_W-1:0]      cfg_data,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ctm_pkg::S_DATA_W-1:0]   s_tdata,  // played_mask[11:0], bass_pc[15:12]
    // result items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ctm_pkg::M_DATA_W-1:0]   m_tdata,  // root[3:0], type_index[9:4],
                                                     // score[11:10], zero[15:12]
    output logic                           m_tuser   // found
);

    localparam int PC_COUNT = ctm_pkg::PC_COUNT;

    ctm_pkg::cnt_t       min_tones_reg;

    // stage 1: input register
    logic                v1_reg;
    ctm_pkg::pc_mask_t   played1_reg;
    ctm_pkg::pc_t        bass1_reg;
    ctm_pkg::pc_t        bass_in;
    ctm_pkg::pc_t        bass_raw;

    // stage 2: best reading per root
    logic                v2_reg;
    ctm_pkg::ctm_cand_t  cand2_reg [PC_COUNT];
    ctm_pkg::ctm_cand_t  cand_next [PC_COUNT];

    // stage 3: result register
    logic                v3_reg;
    ctm_pkg::ctm_cand_t  best_next;
    ctm_pkg::ctm_cand_t  out_reg;

    logic                ready1;
    logic                ready2;
    logic                ready3;

    // Each stage takes a new item when it is empty or its item moves on
    assign ready3   = !v3_reg || m_tready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;

    assign cfg_ready = 1'b1;

    // Fold a bass of 12..15 back into the octave
    assign bass_raw = s_tdata[ctm_pkg::S_DATA_W-1:ctm_pkg::PC_W];
    assign bass_in  = (bass_raw >= ctm_pkg::ROOT_W'(PC_COUNT))
                    ? bass_raw - ctm_pkg::ROOT_W'(PC_COUNT) : bass_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_tones_reg <= ctm_pkg::CNT_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            min_tones_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_tvalid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload: load on advance, hold otherwise
    always_ff @(posedge aclk) begin
        if (ready1 && s_tvalid) begin
            played1_reg <= s_tdata[ctm_pkg::PC_W-1:0];
            bass1_reg   <= bass_in;
        end
        if (ready2 && v1_reg) begin
            cand2_reg <= cand_next;
        end
        if (ready3 && v2_reg) begin
            out_reg <= best_next;
        end
    end

    // One matcher per candidate root
    for (genvar r = 0; r < PC_COUNT; r++) begin : g_root
        ctm_root_match u_root_match (
            .played    (played1_reg),
            .bass      (bass1_reg),
            .root      (ctm_pkg::ROOT_W'(r)),
            .min_tones (min_tones_reg),
            .cand      (cand_next[r])
        );
    end

    ctm_select u_select (
        .cands (cand2_reg),
        .best  (best_next)
    );

    // Drop the fields of a reading that found nothing
    assign m_tvalid = v3_reg;
    assign m_tuser  = out_reg.found;
    assign m_tdata  = out_reg.found
                    ? {{(ctm_pkg::M_DATA_W - ctm_pkg::SCORE_W - ctm_pkg::ROW_W
                         - ctm_pkg::ROOT_W){1'b0}},
                       out_reg.score, out_reg.row, out_reg.root}
                    : '0;

    `CTM_ASSERT_NOW(a_not_found_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata == '0)
    `CTM_ASSERT_NOW(a_found_in_range, aclk, aresetn, m_tvalid && m_tuser,
        (m_tdata[3:0] < 4'd12) && (m_tdata[9:4] < 6'd34))
    `CTM_ASSERT_NOW(a_empty_stage_ready, aclk, aresetn, !v1_reg, s_tready)
    `CTM_ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_tvalid && s_tready, v1_reg)

endmodule

// ===== design/ctm_root_match.sv =====
// ----------------------------------------------------------------------------
// Chord template matcher: one root
// Rotates the set onto a root and finds the best template for that root.
// ----------------------------------------------------------------------------
module ctm_root_match (
    input  ctm_pkg::pc_mask_t  played,
    input  ctm_pkg::pc_t       bass,
    input  ctm_pkg::pc_t       root,
    input  ctm_pkg::cnt_t      min_tones,
    output ctm_pkg::ctm_cand_t cand
);

    logic [2*ctm_pkg::PC_W-1:0]          doubled;
    ctm_pkg::pc_mask_t                   rot;
    logic [ctm_pkg::TEMPLATE_COUNT-1:0]  qual;
    logic [ctm_pkg::TEMPLATE_COUNT-1:0]  exact;
    ctm_pkg::row_t                       qual_row;
    ctm_pkg::row_t                       exact_row;

    // Rotate down so that the root sits on bit 0
    assign doubled = {played, played} >> root;
    assign rot     = doubled[ctm_pkg::PC_W-1:0];

    always_comb begin
        for (int i = 0; i < ctm_pkg::TEMPLATE_COUNT; i++) begin
            qual[i]  = (ctm_pkg::TONE_COUNT[i] >= min_tones)
                    && ((rot & ~ctm_pkg::TONES[i]) == '0)
                    && ((rot & ctm_pkg::NEEDED[i]) == ctm_pkg::NEEDED[i]);
            exact[i] = qual[i] && (rot == ctm_pkg::TONES[i]);
        end
    end

    // Lowest qualifying row, and lowest exact row
    always_comb begin
        qual_row  = '0;
        exact_row = '0;
        for (int i = ctm_pkg::TEMPLATE_COUNT - 1; i >= 0; i--) begin
            if (qual[i]) begin
                qual_row = ctm_pkg::ROW_W'(i);
            end
            if (exact[i]) begin
                exact_row = ctm_pkg::ROW_W'(i);
            end
        end
    end

    always_comb begin
        cand.found = |qual;
        cand.score = {|exact, (root == bass)};
        cand.row   = (|exact) ? exact_row : qual_row;
        cand.root  = root;
    end

endmodule

// ===== design/ctm_select.sv =====
// ----------------------------------------------------------------------------
// Chord template matcher: root selection
// Picks the winning reading over all roots with a comparison tree.
// ----------------------------------------------------------------------------
module ctm_select (
    input  ctm_pkg::ctm_cand_t cands [ctm_pkg::PC_COUNT],
    output ctm_pkg::ctm_cand_t best
);

    ctm_pkg::ctm_cand_t lvl1 [6];
    ctm_pkg::ctm_cand_t lvl2 [3];
    ctm_pkg::ctm_cand_t lvl3;

    // A found reading first, then higher score, then lower row, then lower root
    function automatic ctm_pkg::ctm_cand_t pick(input ctm_pkg::ctm_cand_t a,
                                                input ctm_pkg::ctm_cand_t b);
        logic [12:0] key_a;
        logic [12:0] key_b;
        key_a = {a.found, a.score, ~a.row, ~a.root};
        key_b = {b.found, b.score, ~b.row, ~b.root};
        return (key_a >= key_b) ? a : b;
    endfunction

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            lvl1[i] = pick(cands[2*i], cands[2*i+1]);
        end
        for (int i = 0; i < 3; i++) begin
            lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
        end
        lvl3 = pick(lvl2[0], lvl2[1]);
        best = pick(lvl3, lvl2[2]);
    end

endmodule

// ===== tb/sv/chord_template_matcher_unit_test_pkg.sv =====
// ----------------------------------------------------------------------------
// Chord recognition scoreboard
// Own copy of the chord ROM, a predictor of the winning reading and a queue of
// awaited readings that accepted results are checked against, oldest first.
// ----------------------------------------------------------------------------
package chord_recognition_check_pkg;

    localparam int ROW_COUNT = 34;

    // Chord tones and required tones per row, priority order (row 0 = maj7(9)).
    localparam logic [11:0] CHORD_TONES [ROW_COUNT] = '{
        12'h895, 12'h295, 12'h88D, 12'h48D, 12'h4A9, 12'h495, 12'h691, 12'h493,
        12'h499, 12'h591, 12'h4D5, 12'h8D5, 12'h451, 12'h911, 12'h511, 12'h891,
        12'h491, 12'h489, 12'h889, 12'h449, 12'h249, 12'h289, 12'h291, 12'h4A1,
        12'h095, 12'h08D, 12'h091, 12'h089, 12'h049, 12'h111, 12'h0A1, 12'h085,
        12'h081, 12'h001
    };

    localparam logic [11:0] CHORD_REQUIRED [ROW_COUNT] = '{
        12'h815, 12'h215, 12'h80D, 12'h40D, 12'h429, 12'h415, 12'h611, 12'h413,
        12'h419, 12'h591, 12'h4D1, 12'h851, 12'h451, 12'h911, 12'h511, 12'h811,
        12'h411, 12'h409, 12'h809, 12'h449, 12'h249, 12'h209, 12'h211, 12'h421,
        12'h015, 12'h00D, 12'h091, 12'h089, 12'h049, 12'h111, 12'h021, 12'h005,
        12'h081, 12'h001
    };

    typedef struct packed {
        logic       found;
        logic [3:0] root;
        logic [5:0] row;
        logic [1:0] score;
    } chord_reading_t;

    class chord_scoreboard;
        chord_reading_t awaited[$];
        logic [3:0]     min_tones;
        int             mismatches;

        function new();
            min_tones  = 4'd1;
            mismatches = 0;
        endfunction

        // Best reading over all roots and rows: score, then row, then root.
        function chord_reading_t recognise(input logic [11:0] played,
                                           input logic [3:0] bass_raw);
            chord_reading_t best;
            logic [23:0]    twice;
            logic [11:0]    rot;
            int             bass;
            int             sc;
            bit             have;
            best  = '0;
            have  = 1'b0;
            bass  = int'(bass_raw) % 12;
            twice = {played, played};
            if (played != 12'd0) begin
                for (int r = 0; r < 12; r++) begin
                    rot = 12'(twice >> r);
                    for (int i = 0; i < ROW_COUNT; i++) begin
                        if ($countones(CHORD_TONES[i]) < int'(min_tones)) continue;
                        if ((rot & ~CHORD_TONES[i]) != 12'd0) continue;
                        if ((rot & CHORD_REQUIRED[i]) != CHORD_REQUIRED[i]) continue;
                        sc = (rot == CHORD_TONES[i] ? 2 : 0) + (r == bass ? 1 : 0);
                        if (!have || sc > int'(best.score) ||
                            (sc == int'(best.score) && i < int'(best.row))) begin
                            have        = 1'b1;
                            best.found  = 1'b1;
                            best.score  = 2'(sc);
                            best.row    = 6'(i);
                            best.root   = 4'(r);
                        end
                    end
                end
            end
            return best;
        endfunction

        function void note_played(input logic [11:0] played, input logic [3:0] bass);
            awaited.push_back(recognise(played, bass));
        endfunction

        task report_mismatch(input string what, input int wanted, input int got);
            mismatches++;
            $display("mismatch: %s, expected %0d, got %0d", what, wanted, got);
        endtask

        task check_reading(input logic found, input logic [3:0] root,
                           input logic [5:0] row, input logic [1:0] score,
                           input logic [3:0] pad);
            chord_reading_t want;
            if (awaited.size() == 0) begin
                report_mismatch("result with no item awaiting it", 0, 1);
            end else begin
                want = awaited.pop_front();
                if (found !== want.found) report_mismatch("found", want.found, found);
                if (root !== want.root) report_mismatch("root", want.root, root);
                if (row !== want.row) report_mismatch("type_index", want.row, row);
                if (score !== want.score) report_mismatch("score", want.score, score);
                if (pad !== 4'd0) report_mismatch("tdata padding", 0, pad);
            end
        endtask

        function int pending();
            return awaited.size();
        endfunction

        task check_drained();
            if (awaited.size() != 0)
                report_mismatch("results never delivered", 0, awaited.size());
        endtask
    endclass

endpackage

// ===== tb/sv/chord_template_matcher_unit_test.sv =====
// ----------------------------------------------------------------------------
// Chord template matcher unit test
// Drives pitch-class sets with bass notes through the unit under several
// minimum chord-tone settings, with random gaps on the sender and random
// stalls on the receiver, and checks every result against a predictor.
// ----------------------------------------------------------------------------
module chord_template_matcher_unit_test;
    import chord_recognition_check_pkg::*;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [ctm_pkg::CNT_W-1:0]    cfg_data = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [ctm_pkg::S_DATA_W-1:0] s_tdata = '0;   // played_mask[11:0], bass_pc[15:12]
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [ctm_pkg::M_DATA_W-1:0] m_tdata;        // root[3:0], type_index[9:4],
                                                  // score[11:10], zero[15:12]
    logic                         m_tuser;        // found

    chord_scoreboard readings;
    bit              sender_calm   = 1'b0;
    bit              receiver_calm = 1'b0;

    // Directed sets, {bass, played}: empty and full sets, lone notes, exact
    // templates, rotated chords, symmetric chords and out-of-range bass notes.
    localparam int DIRECTED_COUNT = 22;
    localparam logic [15:0] DIRECTED [DIRECTED_COUNT] = '{
        16'h0_000, 16'hF_FFF, 16'hC_001, 16'hB_800, 16'h0_895, 16'h0_091,
        16'h4_091, 16'hD_089, 16'hE_244, 16'hF_0A1, 16'h0_081, 16'h0_001,
        16'h0_4D5, 16'h0_8D5, 16'h0_111, 16'h4_111, 16'h0_049, 16'h9_249,
        16'h0_555, 16'h0_015, 16'hB_FFE, 16'h7_691
    };

    // Minimum chord-tone settings, one per phase, and the random items in each.
    localparam int PHASE_COUNT = 9;
    localparam int PHASE_MIN   [PHASE_COUNT] = '{4, 0, 12, 6, 3, 2, 5, 7, 1};
    localparam int PHASE_ITEMS [PHASE_COUNT] = '{110, 60, 20, 40, 100, 60, 50, 20, 70};

    chord_template_matcher_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Draw a random wait; now and then flip into or out of a calm
    // stretch where no waits are drawn at all.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 24) == 0) calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 10));
    endfunction

    // Offer one item and hold it until taken. Valid stays high across
    // back-to-back items so it is never dropped and raised in one step.
    task send_item(input logic [11:0] played, input logic [3:0] bass);
        int gap;
        gap = draw_wait(sender_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {bass, played};
        do @(posedge aclk); while (!s_tready);
        readings.note_played(played, bass);
    endtask

    // Drop valid and hold until every awaited reading has come back.
    task drain_results();
        s_tvalid <= 1'b0;
        while (readings.pending() != 0) @(posedge aclk);
    endtask

    task write_min_tones(input logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        readings.min_tones = value;
    endtask

    // Mostly well-formed chords: a random row's required tones plus a random
    // pick of its optional tones, rotated onto a random root, sometimes with
    // a stray note. The rest are arbitrary sets.
    task make_random_item(output logic [11:0] played, output logic [3:0] bass);
        int          row;
        int          root;
        logic [11:0] shape;
        logic [23:0] spun;
        if ($urandom_range(0, 3) != 0) begin
            row   = $urandom_range(0, ROW_COUNT - 1);
            root  = $urandom_range(0, 11);
            shape = CHORD_REQUIRED[row] |
                    (CHORD_TONES[row] & ~CHORD_REQUIRED[row] & 12'($urandom));
            if ($urandom_range(0, 7) == 0) shape = shape | (12'd1 << $urandom_range(0, 11));
            spun   = {shape, shape} << root;
            played = spun[23:12];
            bass   = ($urandom_range(0, 1) == 0) ? 4'(root) : 4'($urandom_range(0, 15));
        end else begin
            played = 12'($urandom);
            bass   = 4'($urandom_range(0, 15));
        end
    endtask

    // Receiver: stall at random, then take one result and check it.
    initial begin : result_sink
        int stall;
        forever begin
            stall = draw_wait(receiver_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
            readings.check_reading(m_tuser, m_tdata[3:0], m_tdata[9:4],
                                   m_tdata[11:10], m_tdata[15:12]);
        end
    end

    initial begin : stimulus
        logic [11:0] played;
        logic [3:0]  bass;
        readings = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed sets run at the reset minimum of one chord tone.
        for (int d = 0; d < DIRECTED_COUNT; d++)
            send_item(DIRECTED[d][11:0], DIRECTED[d][15:12]);

        // Each phase waits for an idle unit before changing the minimum.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            drain_results();
            write_min_tones(4'(PHASE_MIN[p]));
            for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
                make_random_item(played, bass);
                send_item(played, bass);
            end
        end

        // Hold past the last result to catch strays.
        drain_results();
        repeat (10) @(posedge aclk);
        readings.check_drained();
        if (readings.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
